### src/kcs_pkg.sv
// Shared types and constants for the keyframe channel sampler.
package kcs_pkg;

  localparam int SAMPLE_DEPTH_DEF = 4096;
  localparam int CHANNELS_DEF     = 1024;

  localparam logic [1:0] OP_WR_SAMPLE = 2'd0;
  localparam logic [1:0] OP_WR_CHAN   = 2'd1;
  localparam logic [1:0] OP_EVAL      = 2'd2;
  localparam logic [1:0] OP_RD_CHAN   = 2'd3;

  localparam logic REG_FPU  = 1'b0;
  localparam logic REG_JCNT = 1'b1;

  localparam logic [23:0] FPU_RESET  = 24'd1966080;
  localparam logic [8:0]  JCNT_RESET = 9'd0;

  typedef struct packed {
    logic load;    // latch the input transaction
    logic swr;     // write the sample store
    logic mul_n;   // new time times frames per unit
    logic mul_p;   // previous time times frames per unit
    logic loc_n;   // register the new position
    logic loc_p;   // register the previous position
    logic rd2;     // second sample read address
    logic cap_a;   // capture the first sample
    logic mul1;    // first product
    logic mul2;    // accumulate and second product
    logic fin;     // write back and load the result register
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
  } sts_t;

endpackage

### src/kcs_ctrl.sv
// Controller state machine of the keyframe channel sampler.
module kcs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  kcs_pkg::sts_t sts,
  output kcs_pkg::cmd_t cmd
);
  import kcs_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_OPS  = 4'd1;
  localparam logic [3:0] S_E1   = 4'd2;
  localparam logic [3:0] S_E2   = 4'd3;
  localparam logic [3:0] S_E3   = 4'd4;
  localparam logic [3:0] S_E4   = 4'd5;
  localparam logic [3:0] S_E5   = 4'd6;
  localparam logic [3:0] S_E6   = 4'd7;
  localparam logic [3:0] S_WB   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       ovld_r, ovld_nxt;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovld_r;
  assign out_free  = !ovld_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_OPS;
        end
      end
      S_OPS: begin
        if (sts.op == OP_EVAL) begin
          cmd.mul_n = 1'b1;
          state_nxt = S_E2;
        end else begin
          cmd.swr   = (sts.op == OP_WR_SAMPLE);
          state_nxt = S_WB;
        end
      end
      S_E1: state_nxt = S_E2;
      S_E2: begin
        cmd.loc_n = 1'b1;
        cmd.mul_p = 1'b1;
        state_nxt = S_E3;
      end
      S_E3: begin
        cmd.loc_p = 1'b1;
        state_nxt = S_E4;
      end
      S_E4: begin
        cmd.rd2   = 1'b1;
        cmd.cap_a = 1'b1;
        state_nxt = S_E5;
      end
      S_E5: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_E6;
      end
      S_E6: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        if (out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (cmd.fin) begin
      ovld_nxt = 1'b1;
    end else if (ovld_r && !out_stall) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

### src/kcs_dp.sv
// Datapath of the keyframe channel sampler: stores, registers and arithmetic.
module kcs_dp #(
  parameter int SAMPLE_DEPTH = kcs_pkg::SAMPLE_DEPTH_DEF,
  parameter int CHANNELS     = kcs_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic [1:0]          in_opcode,
  input  logic [9:0]          in_channel,
  input  logic [11:0]         in_sample_base,
  input  logic [12:0]         in_sample_count,
  input  logic signed [31:0]  in_value,
  input  logic [31:0]         in_prev_time,
  input  logic [31:0]         in_new_time,
  input  logic [15:0]         in_stream_offset,
  input  logic [15:0]         in_stream_count,
  input  logic [15:0]         in_stream_tail,
  input  logic [17:0]         in_global_frames,
  input  logic                in_additive,
  input  kcs_pkg::cmd_t       cmd,
  output kcs_pkg::sts_t       sts,
  output logic signed [31:0]  out_result_value,
  output logic                out_changed
);
  import kcs_pkg::*;

  localparam int SA_W = $clog2(SAMPLE_DEPTH);
  localparam int CI_W = $clog2(CHANNELS);

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Configuration registers.
  logic [23:0] fpu_r;
  logic [8:0]  jcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpu_r  <= FPU_RESET;
      jcnt_r <= JCNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FPU:  fpu_r  <= cfg_data;
        REG_JCNT: jcnt_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Latched transaction.
  logic [1:0]  op_r;
  logic [9:0]  chan_r;
  logic [11:0] base_r;
  logic [12:0] scnt_r;
  logic [31:0] val_r, ptime_r, ntime_r;
  logic [15:0] off_r, cnt_r, tail_r;
  logic [17:0] glob_r;
  logic        add_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      chan_r  <= in_channel;
      base_r  <= in_sample_base;
      scnt_r  <= in_sample_count;
      val_r   <= in_value;
      ptime_r <= in_prev_time;
      ntime_r <= in_new_time;
      off_r   <= in_stream_offset;
      cnt_r   <= in_stream_count;
      tail_r  <= in_stream_tail;
      glob_r  <= in_global_frames;
      add_r   <= in_additive;
    end
  end

  assign sts.op = op_r;

  logic [CI_W+9:0] chan_ext;
  logic [CI_W-1:0] ci;
  logic            joint_ok;
  assign chan_ext = (CI_W+10)'(chan_r);
  assign ci       = chan_ext[CI_W-1:0];
  assign joint_ok = ({1'b0, chan_r[9:2]} < jcnt_r);

  // Time to frame position.
  logic [55:0] tp_r;
  always_ff @(posedge clk) begin
    if (cmd.mul_n || cmd.mul_p) begin
      tp_r <= (cmd.mul_p ? ptime_r : ntime_r) * fpu_r;
    end
  end

  logic [33:0]        f_pos;
  logic signed [37:0] f_s, glob_s, off_s, cnt_s, tail_s, o_lim, s_v;
  logic               loc_ok;
  logic [31:0]        loc_pos;

  always_comb begin
    f_pos   = (|tp_r[55:50]) ? {34{1'b1}} : tp_r[49:16];
    f_s     = {4'd0, f_pos};
    glob_s  = {20'd0, glob_r};
    off_s   = {22'd0, off_r};
    cnt_s   = {22'd0, cnt_r};
    tail_s  = {22'd0, tail_r};
    o_lim   = off_s <<< 16;
    s_v     = f_s - o_lim;
    loc_ok  = 1'b1;
    if (f_s + 38'sd4 > ((glob_s - 38'sd1) <<< 16)) loc_ok = 1'b0;
    if (f_s - 38'sd4 < o_lim) loc_ok = 1'b0;
    if (s_v >= ((cnt_s + tail_s) <<< 16)) loc_ok = 1'b0;
    if (s_v > ((cnt_s - 38'sd1) <<< 16)) begin
      if (cnt_r == 16'd0) begin
        loc_ok = 1'b0;
      end else begin
        s_v = (cnt_s - 38'sd1) <<< 16;
      end
    end
    loc_pos = s_v[31:0];
  end

  logic [31:0] npos_r, ppos_r;
  logic        nok_r, pok_r;
  always_ff @(posedge clk) begin
    if (cmd.loc_n) begin
      npos_r <= loc_pos;
      nok_r  <= loc_ok;
    end
    if (cmd.loc_p) begin
      ppos_r <= loc_pos;
      pok_r  <= loc_ok;
    end
  end

  logic [15:0] nidx, nfrac, pidx, pfrac;
  assign nidx  = npos_r[31:16];
  assign nfrac = npos_r[15:0];
  assign pidx  = ppos_r[31:16];
  assign pfrac = ppos_r[15:0];

  logic n_in, p_in, n1_in, cond_ex, cond1, cond2, same_idx;
  assign n_in     = ({1'b0, nidx} < {4'd0, scnt_r});
  assign p_in     = ({1'b0, pidx} < {4'd0, scnt_r});
  assign n1_in    = (({1'b0, nidx} + 17'd1) < {4'd0, scnt_r});
  assign same_idx = pok_r && (pidx == nidx);
  assign cond_ex  = nok_r && joint_ok && n_in;
  assign cond2    = nok_r && joint_ok && n_in;
  assign cond1    = nok_r && pok_r && !same_idx && (pfrac < 16'd65532) && joint_ok && p_in;

  // Sample store with one registered read port.
  logic [31:0]     smem [SAMPLE_DEPTH];
  logic [31:0]     samp_rd, sa_r;
  logic [17:0]     rd_sum, wr_sum;
  logic [SA_W-1:0] rd_addr, wr_addr;

  assign rd_sum  = {6'd0, base_r} + (cmd.rd2 ? (add_r ? {2'd0, pidx} : ({2'd0, nidx} + 18'd1))
                                             : {2'd0, nidx});
  assign rd_addr = rd_sum[SA_W-1:0];
  assign wr_sum  = {6'd0, base_r};
  assign wr_addr = wr_sum[SA_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.swr) begin
      smem[wr_addr] <= val_r;
    end
    samp_rd <= smem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      sa_r <= samp_rd;
    end
  end

  // Channel store, read every cycle at the latched channel.
  logic [31:0] cmem [CHANNELS];
  logic [31:0] ch_q;

  // Shared multiplier.
  logic signed [32:0] ma;
  logic signed [17:0] mb;
  logic signed [50:0] p_r;
  logic signed [34:0] term;
  logic signed [17:0] mulv;
  logic [31:0]        sb_eff;
  logic [31:0]        acc_r;

  assign term   = p_r[50:16];
  assign sb_eff = n1_in ? samp_rd : sa_r;
  assign mulv   = $signed({2'd0, nfrac}) - (same_idx ? $signed({2'd0, pfrac}) : 18'sd0);

  always_comb begin
    if (cmd.mul1) begin
      if (add_r) begin
        ma = $signed(samp_rd);
        mb = $signed(18'd65536 - {2'd0, pfrac});
      end else begin
        ma = $signed(sb_eff) - $signed(sa_r);
        mb = $signed({2'd0, nfrac});
      end
    end else begin
      ma = $signed(sa_r);
      mb = mulv;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1 || cmd.mul2) begin
      p_r <= ma * mb;
    end
    if (cmd.mul2) begin
      if (add_r) begin
        acc_r <= cond1 ? sat32($signed(ch_q) + term) : ch_q;
      end else begin
        acc_r <= sat32($signed(sa_r) + ((nfrac >= 16'd4) ? term : 35'sd0));
      end
    end
  end

  logic [31:0] fin_val;
  logic        fin_chg;

  always_comb begin
    fin_val = ch_q;
    fin_chg = 1'b0;
    case (op_r)
      OP_WR_CHAN: fin_val = val_r;
      OP_EVAL: begin
        if (add_r) begin
          fin_val = cond2 ? sat32($signed(acc_r) + term) : acc_r;
          fin_chg = cond1 || cond2;
        end else begin
          fin_val = cond_ex ? acc_r : ch_q;
          fin_chg = cond_ex;
        end
      end
      default: fin_val = ch_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.fin && (fin_chg || op_r == OP_WR_CHAN)) begin
      cmem[ci] <= fin_val;
    end
    ch_q <= cmem[ci];
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_result_value <= fin_val;
      out_changed      <= fin_chg;
    end
  end

endmodule

### src/keyframe_channel_sampler_top.sv
// Top level of the keyframe channel sampler.
//
//   Channel   Direction  Handshake               Payload
//   in_       input      in_valid / in_stall     opcode, channel, sample and stream fields
//   out_      output     out_valid / out_stall   result_value, changed
//   cfg_      input      cfg_we                  cfg_index, cfg_data
//
// One transaction at a time: writes and reads go straight to write-back; an evaluation
// first forms both time products and reads the samples through the single store port.
// A new transaction is taken while the previous result still waits in the output
// register. Reset (rst_n low, synchronous) restores the registers; the stores are
// undefined until written. A stalled result holds the block in write-back.
module keyframe_channel_sampler_top #(
  parameter int SAMPLE_DEPTH = kcs_pkg::SAMPLE_DEPTH_DEF,
  parameter int CHANNELS     = kcs_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [9:0]         in_channel,
  input  logic [11:0]        in_sample_base,
  input  logic [12:0]        in_sample_count,
  input  logic signed [31:0] in_value,
  input  logic [31:0]        in_prev_time,
  input  logic [31:0]        in_new_time,
  input  logic [15:0]        in_stream_offset,
  input  logic [15:0]        in_stream_count,
  input  logic [15:0]        in_stream_tail,
  input  logic [17:0]        in_global_frames,
  input  logic               in_additive,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result_value,
  output logic               out_changed
);
  import kcs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  kcs_dp #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .CHANNELS     (CHANNELS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_opcode        (in_opcode),
    .in_channel       (in_channel),
    .in_sample_base   (in_sample_base),
    .in_sample_count  (in_sample_count),
    .in_value         (in_value),
    .in_prev_time     (in_prev_time),
    .in_new_time      (in_new_time),
    .in_stream_offset (in_stream_offset),
    .in_stream_count  (in_stream_count),
    .in_stream_tail   (in_stream_tail),
    .in_global_frames (in_global_frames),
    .in_additive      (in_additive),
    .cmd              (cmd),
    .sts              (sts),
    .out_result_value (out_result_value),
    .out_changed      (out_changed)
  );

endmodule

### bench/testbench.sv
// Self-checking testbench for the keyframe channel sampler top level.
`timescale 1ns / 100ps

module testbench;
  import kcs_pkg::*;

  typedef struct {
    logic [1:0]  op;
    logic [9:0]  chan;
    logic [11:0] base;
    logic [12:0] scount;
    logic [31:0] value;
    logic [31:0] ptime;
    logic [31:0] ntime;
    logic [15:0] off;
    logic [15:0] cnt;
    logic [15:0] tail;
    logic [17:0] glob;
    logic        add;
  } kcs_item_t;

  typedef struct {
    kcs_item_t   it;
    bit          typed;
    logic [31:0] val;
    logic        chg;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_FPU;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = OP_RD_CHAN;
  logic [9:0] in_channel = '0;
  logic [11:0] in_sample_base = '0;
  logic [12:0] in_sample_count = '0;
  logic signed [31:0] in_value = '0;
  logic [31:0] in_prev_time = '0;
  logic [31:0] in_new_time = '0;
  logic [15:0] in_stream_offset = '0;
  logic [15:0] in_stream_count = '0;
  logic [15:0] in_stream_tail = '0;
  logic [17:0] in_global_frames = '0;
  logic in_additive = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_result_value;
  logic out_changed;

  keyframe_channel_sampler_top dut (.*);

  // Shadow copy of the block's state.
  logic [31:0] shadow_samples [4096];
  logic [31:0] shadow_channels [1024];
  logic [23:0] shadow_fpu;
  logic [8:0]  shadow_jcnt;

  logic [31:0] want_value_q [$];
  logic        want_changed_q [$];
  int   fail_count = 0;
  bit   calm = 1'b0;
  int   stall_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Key position in Q16.16 within the stream, or -1 when the time falls outside.
  function automatic longint key_position(logic [31:0] t, kcs_item_t it);
    logic [63:0] prod;
    longint f, s, o, c, tl, g;
    prod = ({32'b0, t} * {40'b0, shadow_fpu}) >> 16;
    if (prod > 64'd17179869183) prod = 64'd17179869183;
    f = longint'(prod);
    o = longint'(it.off);
    c = longint'(it.cnt);
    tl = longint'(it.tail);
    g = longint'(it.glob);
    if (f + 4 > (g - 1) * 65536) return -1;
    if (f - 4 < o * 65536) return -1;
    s = f - o * 65536;
    if (s >= (c + tl) * 65536) return -1;
    if (s > (c - 1) * 65536) begin
      if (c == 0) return -1;
      s = (c - 1) * 65536;
    end
    if (s < 0) s = 0;
    return s;
  endfunction

  function automatic longint key_sample(kcs_item_t it, longint idx);
    logic [11:0] addr;
    addr = it.base + idx[11:0];
    return longint'(signed'(shadow_samples[addr]));
  endfunction

  // Applies one transaction to the shadow state and returns the channel afterwards.
  function automatic void apply_transaction(kcs_item_t it, output logic [31:0] rv,
                                            output logic chg);
    longint npos, ppos, nidx, nfrac, pidx, pfrac, mul, a, b, v;
    bit joint_ok;
    chg = 1'b0;
    case (it.op)
      OP_WR_SAMPLE: shadow_samples[it.base] = it.value;
      OP_WR_CHAN:   shadow_channels[it.chan] = it.value;
      OP_EVAL: begin
        npos = key_position(it.ntime, it);
        joint_ok = (it.chan / 4) < shadow_jcnt;
        if (npos >= 0) begin
          nidx = npos >>> 16;
          nfrac = npos & 65535;
          if (it.add) begin
            mul = nfrac;
            ppos = key_position(it.ptime, it);
            if (ppos >= 0) begin
              pidx = ppos >>> 16;
              pfrac = ppos & 65535;
              if (pidx == nidx) begin
                mul -= pfrac;
              end else if (65536 - pfrac > 4 && joint_ok && pidx < it.scount) begin
                v = (key_sample(it, pidx) * (65536 - pfrac)) >>> 16;
                shadow_channels[it.chan] =
                  sat32(longint'(signed'(shadow_channels[it.chan])) + v);
                chg = 1'b1;
              end
            end
            if (joint_ok && nidx < it.scount) begin
              v = (key_sample(it, nidx) * mul) >>> 16;
              shadow_channels[it.chan] =
                sat32(longint'(signed'(shadow_channels[it.chan])) + v);
              chg = 1'b1;
            end
          end else if (joint_ok && nidx < it.scount) begin
            a = key_sample(it, nidx);
            v = a;
            if (nfrac >= 4) begin
              b = (nidx + 1 < it.scount) ? key_sample(it, nidx + 1) : a;
              v = a + (((b - a) * nfrac) >>> 16);
            end
            shadow_channels[it.chan] = sat32(v);
            chg = 1'b1;
          end
        end
      end
      default: ;
    endcase
    rv = shadow_channels[it.chan];
  endfunction

  // Picks a time whose frame position lands near a chosen Q16.16 frame.
  function automatic logic [31:0] time_for_frame(longint frame_q16);
    longint t;
    if (shadow_fpu == 0) return $urandom;
    t = (frame_q16 * 65536) / longint'(shadow_fpu);
    if (t > 64'sd4294967295 || $urandom_range(0, 15) == 0) return $urandom;
    return t[31:0];
  endfunction

  function automatic kcs_item_t random_item();
    kcs_item_t it;
    longint frame;
    int span;
    it.op = 2'($urandom_range(0, 3));
    // Only the channels and samples loaded at the start are ever reached.
    it.chan = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 63))
                                          : 10'($urandom_range(960, 1023));
    it.base = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(4032, 4095))
                                          : 12'($urandom_range(0, 63));
    it.value = $urandom;
    it.add = 1'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      // Noise: the times, offset, count and tail drawn over their whole range.
      it.scount = 13'($urandom_range(0, 64));
      it.ptime = $urandom;
      it.ntime = $urandom;
      it.off = 16'($urandom);
      it.cnt = 16'($urandom);
      it.tail = 16'($urandom);
      it.glob = 18'($urandom_range(0, 196605));
      return it;
    end
    if ($urandom_range(0, 9) < 6) it.op = OP_EVAL;
    it.off = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(65000, 65535))
                                          : 16'($urandom_range(0, 40));
    it.cnt = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
    it.tail = 16'($urandom_range(0, 4));
    it.glob = 18'(it.off + it.cnt + it.tail + $urandom_range(0, 3));
    it.scount = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 4096))
                                            : 13'(it.cnt + $urandom_range(0, 2));
    if (it.scount > 0 && $urandom_range(0, 3) == 0) it.scount -= 13'd1;
    span = it.cnt + it.tail;
    frame = (longint'(it.off) + $urandom_range(0, span)) * 65536;
    frame += ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : $urandom_range(0, 65535);
    it.ntime = time_for_frame(frame);
    if ($urandom_range(0, 2) == 0) frame = (frame & ~longint'(65535)) + $urandom_range(0, 65535);
    else frame = (longint'(it.off) + $urandom_range(0, span)) * 65536 + $urandom_range(0, 65535);
    it.ptime = time_for_frame(frame);
    return it;
  endfunction

  task automatic idle_cycles();
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send(stim_row_t row);
    logic [31:0] rv;
    logic chg;
    idle_cycles();
    in_valid <= 1'b1;
    in_opcode <= row.it.op;
    in_channel <= row.it.chan;
    in_sample_base <= row.it.base;
    in_sample_count <= row.it.scount;
    in_value <= row.it.value;
    in_prev_time <= row.it.ptime;
    in_new_time <= row.it.ntime;
    in_stream_offset <= row.it.off;
    in_stream_count <= row.it.cnt;
    in_stream_tail <= row.it.tail;
    in_global_frames <= row.it.glob;
    in_additive <= row.it.add;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_transaction(row.it, rv, chg);
    want_value_q.push_back(row.typed ? row.val : rv);
    want_changed_q.push_back(row.typed ? row.chg : chg);
  endtask

  // Waits until every result is back, plus the latency of an evaluation.
  task automatic drain();
    in_valid <= 1'b0;
    while (want_value_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [23:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FPU) shadow_fpu = data;
    else shadow_jcnt = data[8:0];
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (want_value_q.size() == 0) begin
        $error("result_value: expected none, actual %h", out_result_value);
        fail_count++;
      end else begin
        if (out_result_value !== want_value_q[0]) begin
          $error("result_value: expected %h, actual %h", want_value_q[0], out_result_value);
          fail_count++;
        end
        if (out_changed !== want_changed_q[0]) begin
          $error("changed: expected %b, actual %b", want_changed_q[0], out_changed);
          fail_count++;
        end
        void'(want_value_q.pop_front());
        void'(want_changed_q.pop_front());
      end
      stall_left = calm ? 0 : $urandom_range(0, 3);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    stim_row_t row;
    stim_row_t directed [$];
    logic [23:0] fpu_set [5];
    logic [8:0] jcnt_set [5];
    shadow_fpu = FPU_RESET;
    shadow_jcnt = JCNT_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every channel and sample the stimulus can reach is written before it is read.
    row = '{default: '0};
    row.it = random_item();
    for (int c = 0; c < 128; c++) begin
      row.it.op = OP_WR_CHAN;
      row.it.chan = (c < 64) ? 10'(c) : 10'(896 + c);
      row.it.value = $urandom;
      send(row);
    end
    for (int s = 0; s < 192; s++) begin
      row.it.op = OP_WR_SAMPLE;
      row.it.base = (s < 128) ? 12'(s) : 12'(3904 + s);
      row.it.value = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20);
      send(row);
    end
    drain();

    // Directed rows under the reset configuration, where no joint is enabled.
    row = '{default: '0};
    row.it = random_item();
    row.it.chan = 10'd5;
    row.it.op = OP_WR_CHAN; row.it.value = 32'h7fffffff;
    row.typed = 1'b1; row.val = 32'h7fffffff; row.chg = 1'b0;
    directed.push_back(row);
    row.it.op = OP_RD_CHAN; directed.push_back(row);
    row.it.op = OP_EVAL; row.it.off = 16'd0; row.it.cnt = 16'd4; row.it.tail = 16'd1;
    row.it.glob = 18'd10; row.it.scount = 13'd4; row.it.ntime = 32'h0001_0000;
    directed.push_back(row);
    row.it.op = OP_WR_CHAN; row.it.chan = 10'd1023; row.it.value = 32'h80000000;
    row.val = 32'h80000000; directed.push_back(row);
    row.it.op = OP_WR_SAMPLE; row.it.base = 12'hfff; directed.push_back(row);
    row.it.op = OP_EVAL; row.it.ntime = 32'hffffffff; row.it.glob = 18'd196605;
    row.it.cnt = 16'hffff; row.it.tail = 16'hffff; directed.push_back(row);
    row.typed = 1'b0;
    for (int k = 0; k < 14; k++) begin
      row.it = random_item();
      row.it.op = (k % 2) ? OP_EVAL : 2'(k % 4);
      directed.push_back(row);
    end
    foreach (directed[k]) send(directed[k]);
    drain();

    fpu_set = '{24'd65536, FPU_RESET, 24'hffffff, 24'd0, 24'd1};
    jcnt_set = '{9'd256, 9'd100, 9'd256, 9'd256, 9'd0};
    row = '{default: '0};
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_FPU, fpu_set[p]);
      write_reg(REG_JCNT, jcnt_set[p]);
      calm = (p == 2);
      for (int k = 0; k < 100; k++) begin
        row.it = random_item();
        send(row);
        if (k == 50) begin
          // Hold the sender until everything in flight has come back.
          in_valid <= 1'b0;
          while (want_value_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
src/kcs_pkg.sv
src/kcs_ctrl.sv
src/kcs_dp.sv
src/keyframe_channel_sampler_top.sv
bench/testbench.sv
